// File: rtl/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types and constants of the state variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int COEF_W    = 32;
    localparam int STATE_W   = 32;
    localparam int CH_W      = 3;
    localparam int REG_IDX_W = 3;
    localparam int VAL_W     = STATE_W + 1;
    localparam int PROD_W    = COEF_W + VAL_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int STEP_W    = 3;

    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_A3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_M0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_M1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_M2 = 3'd5;

    localparam logic [STEP_W-1:0] STEP_A1_IC1 = 3'd0;
    localparam logic [STEP_W-1:0] STEP_A2_V3  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_A2_IC1 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_A3_V3  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_M0_X   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_M1_V1  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_M2_V2  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic              load;
        logic              run;
        logic [STEP_W-1:0] step;
        logic              finish;
    } seq_ctrl_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] m0;
        logic signed [COEF_W-1:0] m1;
        logic signed [COEF_W-1:0] m2;
    } coef_set_t;

endpackage

// File: rtl/svf_if.sv
// ----------------------------------------------------------------------------
// svf_if
// Sample, result and register write channels of the state variable filter.
// ----------------------------------------------------------------------------
interface svf_in_if import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

interface svf_out_if import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic [CH_W-1:0]                out_channel;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           clipped;

    modport source (output valid, output out_channel, output out_sample, output clipped,
                    input ready);
    modport sink (input valid, input out_channel, input out_sample, input clipped,
                  output ready);
endinterface

interface svf_cfg_if import svf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/svf_seq.sv
// ----------------------------------------------------------------------------
// svf_seq
// Sequencer: steps the shared multiply-accumulate unit through one item.
// ----------------------------------------------------------------------------
module svf_seq import svf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      slot_free,
    output logic      in_ready,
    output seq_ctrl_t ctrl
);

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.run    = 1'b0;
        ctrl.step   = step_reg;
        ctrl.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_RUN:
            begin
                ctrl.run = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.finish = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/svf_store.sv
// ----------------------------------------------------------------------------
// svf_store
// Per-channel integrator states with registered read and written flags.
// ----------------------------------------------------------------------------
module svf_store import svf_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [CH_W-1:0]           rd_channel,
    input  logic                      wr_en,
    input  logic signed [STATE_W-1:0] wr_one,
    input  logic signed [STATE_W-1:0] wr_two,
    output logic signed [STATE_W-1:0] rd_one,
    output logic signed [STATE_W-1:0] rd_two
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [STATE_W-1:0] one_mem [CHANNELS];
    logic signed [STATE_W-1:0] two_mem [CHANNELS];
    logic [CHANNELS-1:0]       written_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      in_range_reg;
    logic                      hit_reg;
    logic signed [STATE_W-1:0] one_reg;
    logic signed [STATE_W-1:0] two_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      in_range;

    assign rd_addr  = ADDR_W'(rd_channel);
    assign in_range = 32'(rd_channel) < CHANNELS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            hit_reg      <= 1'b0;
            in_range_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                in_range_reg <= in_range;
                hit_reg      <= in_range && written_reg[rd_addr];
            end
            if (wr_en && in_range_reg)
            begin
                written_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_reg <= rd_addr;
            one_reg  <= one_mem[rd_addr];
            two_reg  <= two_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && in_range_reg)
        begin
            one_mem[addr_reg] <= wr_one;
            two_mem[addr_reg] <= wr_two;
        end
    end

    assign rd_one = hit_reg ? one_reg : '0;
    assign rd_two = hit_reg ? two_reg : '0;

endmodule

// File: rtl/svf_mac.sv
// ----------------------------------------------------------------------------
// svf_mac
// Shared multiplier with rounding accumulator, node and state saturation.
// ----------------------------------------------------------------------------
module svf_mac import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  seq_ctrl_t                      ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  coef_set_t                      coef,
    input  logic signed [STATE_W-1:0]      ic1,
    input  logic signed [STATE_W-1:0]      ic2,
    output logic                           wr_en,
    output logic signed [STATE_W-1:0]      wr_one,
    output logic signed [STATE_W-1:0]      wr_two,
    output logic signed [SAMPLE_WIDTH-1:0] y,
    output logic                           clip
);

    localparam int DIFF_W = STATE_W + 2;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [VAL_W-1:0]        v3_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [STATE_W-1:0]      v1_reg;
    logic signed [STATE_W-1:0]      v2_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           clip_reg;

    logic signed [COEF_W-1:0] coef_op;
    logic signed [VAL_W-1:0]  val_op;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  sum;
    logic                     sum_ovf32;
    logic signed [STATE_W-1:0] sum_sat32;
    logic                     sum_ovfy;
    logic signed [SAMPLE_WIDTH-1:0] sum_saty;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
    logic                     d1_ovf;
    logic                     d2_ovf;

    always_comb
    begin
        coef_op = coef.a1;
        val_op  = VAL_W'(ic1);
        case (ctrl.step)
            STEP_A1_IC1:
            begin
                coef_op = coef.a1;
                val_op  = VAL_W'(ic1);
            end
            STEP_A2_V3:
            begin
                coef_op = coef.a2;
                val_op  = v3_reg;
            end
            STEP_A2_IC1:
            begin
                coef_op = coef.a2;
                val_op  = VAL_W'(ic1);
            end
            STEP_A3_V3:
            begin
                coef_op = coef.a3;
                val_op  = v3_reg;
            end
            STEP_M0_X:
            begin
                coef_op = coef.m0;
                val_op  = VAL_W'(x_reg);
            end
            STEP_M1_V1:
            begin
                coef_op = coef.m1;
                val_op  = VAL_W'(v1_reg);
            end
            STEP_M2_V2:
            begin
                coef_op = coef.m2;
                val_op  = VAL_W'(v2_reg);
            end
            default:
            begin
                coef_op = coef.a1;
                val_op  = VAL_W'(ic1);
            end
        endcase
    end

    // round to nearest, ties up
    assign rnd = (ACC_W'(prod_reg) + HALF) >>> COEF_FRAC_BITS;

    always_comb
    begin
        base = acc_reg;
        case (ctrl.step)
            STEP_A2_V3:  base = '0;
            STEP_A3_V3:  base = ACC_W'(ic2);
            STEP_M1_V1:  base = '0;
            default:     base = acc_reg;
        endcase
    end

    assign sum = base + rnd;

    assign sum_ovf32 = !((&sum[ACC_W-1:STATE_W-1]) || !(|sum[ACC_W-1:STATE_W-1]));
    assign sum_sat32 = sum_ovf32 ? (sum[ACC_W-1] ? STATE_MIN : STATE_MAX)
                                 : sum[STATE_W-1:0];
    assign sum_ovfy  = !((&sum[ACC_W-1:SAMPLE_WIDTH-1]) || !(|sum[ACC_W-1:SAMPLE_WIDTH-1]));
    assign sum_saty  = sum_ovfy ? (sum[ACC_W-1] ? Y_MIN : Y_MAX)
                                : sum[SAMPLE_WIDTH-1:0];

    assign d1 = (DIFF_W'(v1_reg) <<< 1) - DIFF_W'(ic1);
    assign d2 = (DIFF_W'(v2_reg) <<< 1) - DIFF_W'(ic2);
    assign d1_ovf = !((&d1[DIFF_W-1:STATE_W-1]) || !(|d1[DIFF_W-1:STATE_W-1]));
    assign d2_ovf = !((&d2[DIFF_W-1:STATE_W-1]) || !(|d2[DIFF_W-1:STATE_W-1]));

    assign wr_en  = ctrl.run && (ctrl.step == STEP_M1_V1);
    assign wr_one = d1_ovf ? (d1[DIFF_W-1] ? STATE_MIN : STATE_MAX) : d1[STATE_W-1:0];
    assign wr_two = d2_ovf ? (d2[DIFF_W-1] ? STATE_MIN : STATE_MAX) : d2[STATE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            clip_reg <= 1'b0;
        end
        else if (ctrl.run)
        begin
            case (ctrl.step)
                STEP_A2_IC1: clip_reg <= clip_reg | sum_ovf32;
                STEP_M0_X:   clip_reg <= clip_reg | sum_ovf32;
                STEP_M1_V1:  clip_reg <= clip_reg | d1_ovf | d2_ovf;
                STEP_LAST:   clip_reg <= clip_reg | sum_ovfy;
                default:     clip_reg <= clip_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= sample;
        end
        if (ctrl.run)
        begin
            prod_reg <= coef_op * val_op;
            acc_reg  <= sum;
            case (ctrl.step)
                STEP_A1_IC1: v3_reg <= VAL_W'(x_reg) - VAL_W'(ic2);
                STEP_A2_IC1: v1_reg <= sum_sat32;
                STEP_M0_X:   v2_reg <= sum_sat32;
                STEP_LAST:   y_reg  <= sum_saty;
                default:     ;
            endcase
        end
    end

    assign y    = y_reg;
    assign clip = clip_reg;

endmodule

// File: rtl/svf_biquad_filter.sv
// ----------------------------------------------------------------------------
// svf_biquad_filter
// Multi-channel trapezoidal state variable filter, one shared multiplier.
// ----------------------------------------------------------------------------
// Channels: samples (sink) takes a channel number and a signed sample;
// results (source) gives the channel, the filtered sample and a clip flag;
// cfg (sink) writes the six coefficient registers by index and is always
// ready. Indexes past the last register are dropped.
// Each item runs eight steps through one 32x33 multiplier with a rounding
// accumulator, one product per step. The sequencer takes the item in IDLE,
// runs the steps in RUN and hands the result to the output register in
// DONE. It takes no new item before the last one has left DONE.
// samples.ready is high only between items; it may rise while an earlier
// result still waits in the output register.
// Reset clears all integrator states to zero and loads the pass-through
// coefficients (a1 = m0 = 1.0, others 0). When the receiver stalls, the
// result holds and a finished item waits until the output register frees.
// ----------------------------------------------------------------------------
module svf_biquad_filter import svf_pkg::*; #(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 24
) (
    input logic        clk,
    input logic        rst_n,
    svf_in_if.sink     samples,
    svf_out_if.source  results,
    svf_cfg_if.sink    cfg
);

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    coef_set_t                      coef_reg;
    seq_ctrl_t                      ctrl;
    logic                           slot_free;
    logic [CH_W-1:0]                chan_reg;
    logic                           out_valid_reg;
    logic [CH_W-1:0]                out_channel_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           clipped_reg;
    logic signed [STATE_W-1:0]      ic1;
    logic signed [STATE_W-1:0]      ic2;
    logic                           wr_en;
    logic signed [STATE_W-1:0]      wr_one;
    logic signed [STATE_W-1:0]      wr_two;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic                           clip;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.a1 <= COEF_ONE;
            coef_reg.a2 <= '0;
            coef_reg.a3 <= '0;
            coef_reg.m0 <= COEF_ONE;
            coef_reg.m1 <= '0;
            coef_reg.m2 <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_A1:  coef_reg.a1 <= cfg.data;
                REG_A2:  coef_reg.a2 <= cfg.data;
                REG_A3:  coef_reg.a3 <= cfg.data;
                REG_M0:  coef_reg.m0 <= cfg.data;
                REG_M1:  coef_reg.m1 <= cfg.data;
                REG_M2:  coef_reg.m2 <= cfg.data;
                default: coef_reg    <= coef_reg;
            endcase
        end
    end

    assign slot_free = !out_valid_reg || results.ready;

    svf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .slot_free (slot_free),
        .in_ready  (samples.ready),
        .ctrl      (ctrl)
    );

    svf_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (ctrl.load),
        .rd_channel (samples.channel),
        .wr_en      (wr_en),
        .wr_one     (wr_one),
        .wr_two     (wr_two),
        .rd_one     (ic1),
        .rd_two     (ic2)
    );

    svf_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (samples.sample),
        .coef   (coef_reg),
        .ic1    (ic1),
        .ic2    (ic2),
        .wr_en  (wr_en),
        .wr_one (wr_one),
        .wr_two (wr_two),
        .y      (y),
        .clip   (clip)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            chan_reg <= samples.channel;
        end
        if (ctrl.finish)
        begin
            out_channel_reg <= chan_reg;
            out_sample_reg  <= y;
            clipped_reg     <= clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.out_sample  = out_sample_reg;
    assign results.clipped     = clipped_reg;

endmodule

// File: rtl/svf_checker.sv
// ----------------------------------------------------------------------------
// svf_checker
// Port-level checks of the state variable filter, bound to the top level.
// ----------------------------------------------------------------------------
module svf_checker import svf_pkg::*; #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [CH_W-1:0]         out_channel,
    input logic [SAMPLE_WIDTH-1:0] out_sample,
    input logic                    clipped
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // busy at the start and at the end of the item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready ##8 !in_ready)
        else $error("sample channel ready while an item is in progress");

    // an item taken while the output register is empty yields a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !out_valid |-> ##10 out_valid)
        else $error("result not valid ten cycles after the item");

    // no result without an item in progress before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a finished item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_channel) && $stable(out_sample) && $stable(clipped))
        else $error("stalled result changed");

endmodule

bind svf_biquad_filter svf_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_svf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_channel (results.out_channel),
    .out_sample  (results.out_sample),
    .clipped     (results.clipped)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel state variable filter. A short
// table of directed items (pass-through after reset, coefficient extremes,
// rounding ties, ignored register writes, saturating states) is followed by
// random phases, each with fresh coefficients: designed filter responses,
// raw random words and extreme values. A cycle-free predictor tracks the
// coefficients and the per-channel integrators, and every result is checked
// in order against it or the table. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import svf_pkg::*;;

    localparam int SAMPLE_W      = 24;
    localparam int FRAC_BITS     = 24;
    localparam int NUM_CH        = 8;
    localparam int NUM_COEFS     = 6;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int CALM_PHASE    = 4;
    localparam int DRAIN_CYCLES  = 12;
    localparam int MAX_REPORTS   = 40;
    localparam int NUM_ROWS      = 41;
    localparam real Q_ONE        = 16777216.0;

    localparam logic [REG_IDX_W-1:0] REG_VOID_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_VOID_HI = 3'd7;

    localparam logic [COEF_W-1:0] ONE_Q = 32'h0100_0000;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE,
        ROW_FIXED
    } row_kind_t;

    typedef enum int {
        SET_DESIGNED,
        SET_NOISE,
        SET_EXTREME
    } coef_set_kind_t;

    typedef enum int {
        MODE_LOW,
        MODE_BAND,
        MODE_HIGH,
        MODE_NOTCH,
        MODE_PEAK,
        MODE_BELL,
        MODE_SHELF
    } filt_mode_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [REG_IDX_W-1:0]       idx;
        logic [COEF_W-1:0]          data;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic                       clip;
    } dir_row_t;

    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] y;
        logic                       clip;
    } filt_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;
    int   errors = 0;

    logic signed [COEF_W-1:0]  coef [NUM_COEFS];
    logic signed [STATE_W-1:0] integ_one [NUM_CH];
    logic signed [STATE_W-1:0] integ_two [NUM_CH];
    filt_result_t              awaited_results [$];

    logic [COEF_W-1:0] extreme_coefs [5] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0100_0000, 32'hFF00_0000
    };

    dir_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd7, 24'h7FFFFF,  24'h7FFFFF,  1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd3, 24'h800000,  24'h800000,  1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd5, -24'sd1,     -24'sd1,     1'b0},
        '{ROW_CFG,    REG_M0,      32'h7FFF_FFFF, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd1, 24'h7FFFFF,  24'h7FFFFF,  1'b1},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd2, 24'h800000,  24'h800000,  1'b1},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd4, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_M0,      32'h8000_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd6, 24'sd1,      -24'sd128,   1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd6, 24'h7FFFFF,  24'h800000,  1'b1},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd0, 24'h800000,  24'h7FFFFF,  1'b1},
        '{ROW_CFG,    REG_M0,      32'h0080_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd1, 24'sd1,      24'sd1,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd1, -24'sd1,     24'sd0,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd2, 24'sd3,      24'sd2,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd2, -24'sd3,     -24'sd1,     1'b0},
        '{ROW_CFG,    REG_M0,      32'h0100_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_VOID_LO, 32'hFFFF_FFFF, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_VOID_HI, 32'h8000_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_FIXED,  REG_A1,      32'h0,         3'd3, 24'sd12345,  24'sd12345,  1'b0},
        '{ROW_CFG,    REG_A1,      32'h7FFF_FFFF, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_A2,      32'h7FFF_FFFF, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_A3,      32'h8000_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_M1,      32'h7FFF_FFFF, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_M2,      32'h8000_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd0, 24'h7FFFFF,  24'sd0,      1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd0, 24'h800000,  24'sd0,      1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd0, 24'h7FFFFF,  24'sd0,      1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd7, -24'sd1,     24'sd0,      1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_A1,      32'h0092_4925, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_A2,      32'h0049_2492, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_A3,      32'h0024_9249, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_M0,      32'h0000_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_M1,      32'h0000_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_CFG,    REG_M2,      32'h0100_0000, 3'd0, 24'sd0,      24'sd0,      1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd1, 24'sd4000000, 24'sd0,     1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd1, 24'sd4000000, 24'sd0,     1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd1, -24'sd4000000, 24'sd0,    1'b0},
        '{ROW_SAMPLE, REG_A1,      32'h0,         3'd1, 24'sd0,      24'sd0,      1'b0}
    };

    svf_in_if #(.SAMPLE_WIDTH(SAMPLE_W))  samples_if ();
    svf_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) results_if ();
    svf_cfg_if                            cfg_if ();

    svf_biquad_filter #(
        .CHANNELS       (NUM_CH),
        .SAMPLE_WIDTH   (SAMPLE_W),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        results_if.ready = calm || ($urandom_range(0, 99) >= 7);
    end

    function automatic longint round_product(input logic signed [COEF_W-1:0] c,
                                             input longint v);
        longint p;
        p = longint'(c) * v + (longint'(1) <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(input longint v, input int width, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (width - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic filt_result_t run_filter(input logic [CH_W-1:0] ch,
                                                input logic signed [SAMPLE_W-1:0] x);
        longint       ic1;
        longint       ic2;
        longint       xv;
        longint       v1;
        longint       v2;
        longint       v3;
        longint       n1;
        longint       n2;
        longint       y;
        bit           hit;
        filt_result_t r;
        hit = 1'b0;
        ic1 = longint'(integ_one[ch]);
        ic2 = longint'(integ_two[ch]);
        xv  = longint'(x);
        v3  = xv - ic2;
        v1  = clamp(round_product(coef[REG_A1], ic1) + round_product(coef[REG_A2], v3),
                    STATE_W, hit);
        v2  = clamp(ic2 + round_product(coef[REG_A2], ic1) + round_product(coef[REG_A3], v3),
                    STATE_W, hit);
        n1  = clamp(2 * v1 - ic1, STATE_W, hit);
        n2  = clamp(2 * v2 - ic2, STATE_W, hit);
        integ_one[ch] = STATE_W'(n1);
        integ_two[ch] = STATE_W'(n2);
        y = round_product(coef[REG_M0], xv) + round_product(coef[REG_M1], v1)
            + round_product(coef[REG_M2], v2);
        y = clamp(y, SAMPLE_W, hit);
        r.ch   = ch;
        r.y    = SAMPLE_W'(y);
        r.clip = hit;
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] to_q(input real r);
        return COEF_W'($rtoi(r * Q_ONE));
    endfunction

    function automatic void check_field(input string what, input longint want,
                                        input longint got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        filt_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: result expected none, got channel %0d sample %0d",
                             $time, results_if.out_channel, results_if.out_sample);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("out_channel", longint'(want.ch),
                            longint'(results_if.out_channel));
                check_field("out_sample", longint'(want.y), longint'(results_if.out_sample));
                check_field("clipped", longint'(want.clip), longint'(results_if.clipped));
            end
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x,
                               input bit use_typed, input logic signed [SAMPLE_W-1:0] typed_y,
                               input logic typed_clip);
        filt_result_t predicted;
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            samples_if.valid = 1'b0;
            @(negedge clk);
        end
        samples_if.valid   = 1'b1;
        samples_if.channel = ch;
        samples_if.sample  = x;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        predicted = run_filter(ch, x);
        if (use_typed)
        begin
            predicted.y    = typed_y;
            predicted.clip = typed_clip;
        end
        awaited_results.push_back(predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            cfg_if.valid = 1'b0;
            @(negedge clk);
        end
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx < NUM_COEFS)
            coef[idx] = value;
        @(negedge clk);
    endtask

    // drain all pending results, then let the datapath go quiet
    task automatic settle();
        samples_if.valid = 1'b0;
        cfg_if.valid     = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_coefs(input coef_set_kind_t set_kind);
        logic [COEF_W-1:0] val [NUM_COEFS];
        real               g;
        real               k;
        real               amp;
        real               a1;
        real               m0;
        real               m1;
        real               m2;
        filt_mode_t        mode;
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            if (set_kind == SET_NOISE)
                val[i] = $urandom();
            else
                val[i] = extreme_coefs[$urandom_range(0, 4)];
        end
        if (set_kind == SET_DESIGNED)
        begin
            g    = 0.01 + $urandom_range(0, 2000) / 1000.0;
            k    = 0.1 + $urandom_range(0, 1900) / 1000.0;
            amp  = 0.25 + $urandom_range(0, 3750) / 1000.0;
            a1   = 1.0 / (1.0 + g * (g + k));
            m0   = 1.0;
            m1   = 0.0;
            m2   = 0.0;
            mode = filt_mode_t'($urandom_range(0, 6));
            case (mode)
                MODE_LOW:   begin m0 = 0.0; m2 = 1.0; end
                MODE_BAND:  begin m0 = 0.0; m1 = 1.0; end
                MODE_HIGH:  begin m1 = -k; m2 = -1.0; end
                MODE_NOTCH: m1 = -k;
                MODE_PEAK:  begin m1 = -k; m2 = -2.0; end
                MODE_BELL:  m1 = k * (amp * amp - 1.0);
                MODE_SHELF: begin m1 = k * (amp - 1.0); m2 = amp * amp - 1.0; end
                default:    m0 = 1.0;
            endcase
            val[REG_A1] = to_q(a1);
            val[REG_A2] = to_q(g * a1);
            val[REG_A3] = to_q(g * g * a1);
            val[REG_M0] = to_q(m0);
            val[REG_M1] = to_q(m1);
            val[REG_M2] = to_q(m2);
        end
        write_reg($urandom_range(0, 1) ? REG_VOID_LO : REG_VOID_HI, $urandom());
        for (int i = 0; i < NUM_COEFS; i++)
            write_reg(REG_IDX_W'(i), val[i]);
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        logic signed [SAMPLE_W-1:0] x;
        int unsigned                pick;
        coef_set_kind_t             set_kind;
        samples_if.valid   = 1'b0;
        samples_if.channel = '0;
        samples_if.sample  = '0;
        results_if.ready   = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_A1;
        cfg_if.data        = '0;
        foreach (coef[i])
            coef[i] = '0;
        coef[REG_A1] = ONE_Q;
        coef[REG_M0] = ONE_Q;
        foreach (integ_one[i])
        begin
            integ_one[i] = '0;
            integ_two[i] = '0;
        end
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || directed_rows[i - 1].kind != ROW_CFG)
                    settle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                cfg_if.valid = 1'b0;
                send_sample(directed_rows[i].ch, directed_rows[i].x,
                            directed_rows[i].kind == ROW_FIXED,
                            directed_rows[i].y, directed_rows[i].clip);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            calm = (ph == CALM_PHASE);
            if (ph == 2 || ph == 7)
                set_kind = SET_NOISE;
            else if (ph == 5)
                set_kind = SET_EXTREME;
            else
                set_kind = SET_DESIGNED;
            load_coefs(set_kind);
            cfg_if.valid = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    x = SAMPLE_W'($urandom());
                else if (pick < 85)
                    x = SAMPLE_W'($urandom_range(0, 511) - 256);
                else if (pick[0])
                    x = 24'h7FFFFF;
                else
                    x = 24'h800000;
                send_sample(CH_W'($urandom_range(0, NUM_CH - 1)), x, 1'b0, '0, 1'b0);
            end
        end
        calm = 1'b0;
        settle();

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
